FILE: src/pfno_pkg.sv
package pfno_pkg;

  // field and datapath widths
  localparam int unsigned TagW   = 24;
  localparam int unsigned CoordW = 24;
  localparam int unsigned RelW   = 25;
  localparam int unsigned NormW  = 56;
  localparam int unsigned SumW   = 30;
  localparam int unsigned MulW   = 30;
  localparam int unsigned ProdW  = 2 * MulW;
  localparam int unsigned DotW   = 88;
  // normal is split into two chunks for the dot product
  localparam int unsigned SplitW = 28;

  localparam int unsigned DefMaxFaceVerts = 16;
  localparam int unsigned DefMaxCellVerts = 32;

  // operand pair for the shared multiplier
  typedef enum logic [3:0] {
    MUL_NONE  = 4'd0,
    MUL_P1C2  = 4'd1,
    MUL_P2C1  = 4'd2,
    MUL_P2C0  = 4'd3,
    MUL_P0C2  = 4'd4,
    MUL_P0C1  = 4'd5,
    MUL_P1C0  = 4'd6,
    MUL_CNT_O = 4'd7,
    MUL_NLO   = 4'd8,
    MUL_NHI   = 4'd9
  } mul_sel_e;

  // what happens to the registered product
  typedef enum logic [2:0] {
    ACC_NONE   = 3'd0,
    ACC_N_ADD  = 3'd1,
    ACC_N_SUB  = 3'd2,
    ACC_D_LOAD = 3'd3,
    ACC_DOT_LO = 3'd4,
    ACC_DOT_HI = 3'd5
  } acc_op_e;

  typedef struct packed {
    logic       capture;
    mul_sel_e   mul_sel;
    acc_op_e    acc_op;
    logic [1:0] comp;
    logic       load_origin;
    logic       load_prev;
    logic       face_inc;
    logic       cell_add;
    logic       set_ovf;
    logic       emit;
  } pfno_cmd_t;

  typedef struct packed {
    logic kind;
    logic last;
    logic face_empty;
    logic face_one;
    logic face_full;
    logic cell_full;
  } pfno_stat_t;

endpackage

FILE: src/pfno_ctrl.sv
module pfno_ctrl
  import pfno_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  pfno_stat_t stat_i,
  output pfno_cmd_t  cmd_o,
  output logic       busy_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_CROSS  = 5'b00100,
    ST_FIN    = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  localparam logic [2:0] CrossLast = 3'd6;
  localparam logic [2:0] FinCntO   = 3'd0;
  localparam logic [2:0] FinDLoad  = 3'd1;
  localparam logic [2:0] FinLo     = 3'd2;
  localparam logic [2:0] FinHi     = 3'd3;
  localparam logic [2:0] FinDone   = 3'd4;
  localparam logic [1:0] CompLast  = 2'd2;

  state_e     state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [1:0] comp_q, comp_d;
  pfno_cmd_t  cmd;

  // six partial products of the cross product, in accumulation order
  function automatic mul_sel_e cross_sel(input logic [2:0] step);
    mul_sel_e sel;
    begin
      sel = MUL_NONE;
      unique case (step)
        3'd0:    sel = MUL_P1C2;
        3'd1:    sel = MUL_P2C1;
        3'd2:    sel = MUL_P2C0;
        3'd3:    sel = MUL_P0C2;
        3'd4:    sel = MUL_P0C1;
        3'd5:    sel = MUL_P1C0;
        default: sel = MUL_NONE;
      endcase
      return sel;
    end
  endfunction

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    comp_d  = comp_q;
    cmd     = '0;
    cmd.mul_sel = MUL_NONE;
    cmd.acc_op  = ACC_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd.capture = 1'b1;
          state_d     = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        step_d  = '0;
        comp_d  = '0;
        state_d = stat_i.last ? ST_FIN : ST_IDLE;
        if (!stat_i.kind) begin
          if (stat_i.face_full) begin
            cmd.set_ovf = 1'b1;
          end else if (stat_i.face_empty) begin
            cmd.load_origin = 1'b1;
            cmd.face_inc    = 1'b1;
          end else if (stat_i.face_one) begin
            cmd.load_prev = 1'b1;
            cmd.face_inc  = 1'b1;
          end else begin
            state_d = ST_CROSS;
          end
        end else begin
          if (stat_i.cell_full) begin
            cmd.set_ovf = 1'b1;
          end else begin
            cmd.cell_add = 1'b1;
          end
        end
      end
      ST_CROSS: begin
        if (step_q < CrossLast) begin
          cmd.mul_sel = cross_sel(step_q);
        end
        if (step_q != 3'd0) begin
          cmd.acc_op = step_q[0] ? ACC_N_ADD : ACC_N_SUB;
          cmd.comp   = 2'((step_q - 3'd1) >> 1);
        end
        if (step_q == CrossLast) begin
          cmd.load_prev = 1'b1;
          cmd.face_inc  = 1'b1;
          step_d        = '0;
          state_d       = stat_i.last ? ST_FIN : ST_IDLE;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_FIN: begin
        cmd.comp = comp_q;
        unique case (step_q)
          FinCntO:  cmd.mul_sel = MUL_CNT_O;
          FinDLoad: cmd.acc_op  = ACC_D_LOAD;
          FinLo:    cmd.mul_sel = MUL_NLO;
          FinHi: begin
            cmd.acc_op  = ACC_DOT_LO;
            cmd.mul_sel = MUL_NHI;
          end
          FinDone:  cmd.acc_op  = ACC_DOT_HI;
          default:  cmd.acc_op  = ACC_NONE;
        endcase
        if (step_q == FinDone) begin
          step_d = '0;
          if (comp_q == CompLast) begin
            state_d = ST_EMIT;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      comp_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      comp_q  <= comp_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: src/pfno_datapath.sv
module pfno_datapath
  import pfno_pkg::*;
#(
  parameter int unsigned MAX_FACE_VERTS = DefMaxFaceVerts,
  parameter int unsigned MAX_CELL_VERTS = DefMaxCellVerts
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pfno_cmd_t                cmd_i,
  output pfno_stat_t               stat_o,
  input  logic [TagW-1:0]          face_id_i,
  input  logic                     vertex_kind_i,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic signed [CoordW-1:0] coord_z_i,
  input  logic                     last_item_i,
  output logic                     done_o,
  output logic [TagW-1:0]          face_tag_o,
  output logic signed [NormW-1:0]  normal_x_o,
  output logic signed [NormW-1:0]  normal_y_o,
  output logic signed [NormW-1:0]  normal_z_o,
  output logic                     was_flipped_o,
  output logic                     count_overflow_o
);

  localparam int unsigned FaceCntW = $clog2(MAX_FACE_VERTS + 1);
  localparam int unsigned CellCntW = $clog2(MAX_CELL_VERTS + 1);

  logic signed [CoordW-1:0] coord_in [3];
  logic signed [CoordW-1:0] vin_q    [3];
  logic signed [RelW-1:0]   cur_q    [3];
  logic signed [CoordW-1:0] origin_q [3];
  logic signed [RelW-1:0]   prev_q   [3];
  logic signed [NormW-1:0]  norm_q   [3];
  logic signed [SumW-1:0]   sum_q    [3];
  logic [FaceCntW-1:0]      fcnt_q;
  logic [CellCntW-1:0]      ccnt_q;
  logic                     ovf_q;
  logic signed [DotW-1:0]   dot_q;
  logic signed [SumW-1:0]   d_q;
  logic signed [ProdW-1:0]  prod_q;
  logic                     kind_q, last_q;
  logic [TagW-1:0]          face_id_q;

  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [NormW-1:0]  n_sel;
  logic signed [CoordW-1:0] origin_sel;
  logic signed [SumW-1:0]   sum_sel;
  logic                     flip;

  logic                     done_q;
  logic [TagW-1:0]          tag_q;
  logic signed [NormW-1:0]  nout_q [3];
  logic                     flip_q, ovf_out_q;

  assign coord_in[0] = coord_x_i;
  assign coord_in[1] = coord_y_i;
  assign coord_in[2] = coord_z_i;

  assign n_sel      = norm_q[cmd_i.comp];
  assign origin_sel = origin_q[cmd_i.comp];
  assign sum_sel    = sum_q[cmd_i.comp];

  assign stat_o.kind       = kind_q;
  assign stat_o.last       = last_q;
  assign stat_o.face_empty = (fcnt_q == '0);
  assign stat_o.face_one   = (fcnt_q == FaceCntW'(1));
  assign stat_o.face_full  = (fcnt_q >= FaceCntW'(MAX_FACE_VERTS));
  assign stat_o.cell_full  = (ccnt_q >= CellCntW'(MAX_CELL_VERTS));

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_P1C2: begin mul_a = MulW'(prev_q[1]); mul_b = MulW'(cur_q[2]); end
      MUL_P2C1: begin mul_a = MulW'(prev_q[2]); mul_b = MulW'(cur_q[1]); end
      MUL_P2C0: begin mul_a = MulW'(prev_q[2]); mul_b = MulW'(cur_q[0]); end
      MUL_P0C2: begin mul_a = MulW'(prev_q[0]); mul_b = MulW'(cur_q[2]); end
      MUL_P0C1: begin mul_a = MulW'(prev_q[0]); mul_b = MulW'(cur_q[1]); end
      MUL_P1C0: begin mul_a = MulW'(prev_q[1]); mul_b = MulW'(cur_q[0]); end
      MUL_CNT_O: begin
        mul_a = MulW'(ccnt_q);
        mul_b = MulW'(origin_sel);
      end
      MUL_NLO: begin
        mul_a = MulW'(n_sel[SplitW-1:0]);
        mul_b = d_q;
      end
      MUL_NHI: begin
        mul_a = MulW'($signed(n_sel[NormW-1:SplitW]));
        mul_b = d_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // non-negative and non-zero dot product means the normal faces the cell
  assign flip = !dot_q[DotW-1] && (dot_q != '0);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.capture) begin
      for (int i = 0; i < 3; i++) begin
        vin_q[i] <= coord_in[i];
        cur_q[i] <= RelW'(coord_in[i]) - RelW'(origin_q[i]);
      end
      kind_q    <= vertex_kind_i;
      last_q    <= last_item_i;
      face_id_q <= face_id_i;
    end
    if (cmd_i.acc_op == ACC_D_LOAD) begin
      d_q <= sum_sel - SumW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        prev_q[i]   <= '0;
        norm_q[i]   <= '0;
        sum_q[i]    <= '0;
      end
      fcnt_q <= '0;
      ccnt_q <= '0;
      ovf_q  <= 1'b0;
      dot_q  <= '0;
    end else if (cmd_i.emit) begin
      // job done, back to a clean slate
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        prev_q[i]   <= '0;
        norm_q[i]   <= '0;
        sum_q[i]    <= '0;
      end
      fcnt_q <= '0;
      ccnt_q <= '0;
      ovf_q  <= 1'b0;
      dot_q  <= '0;
    end else begin
      if (cmd_i.load_origin) begin
        for (int i = 0; i < 3; i++) origin_q[i] <= vin_q[i];
      end
      if (cmd_i.load_prev) begin
        for (int i = 0; i < 3; i++) prev_q[i] <= cur_q[i];
      end
      if (cmd_i.face_inc) begin
        fcnt_q <= fcnt_q + FaceCntW'(1);
      end
      if (cmd_i.cell_add) begin
        for (int i = 0; i < 3; i++) sum_q[i] <= sum_q[i] + SumW'(vin_q[i]);
        ccnt_q <= ccnt_q + CellCntW'(1);
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
      case (cmd_i.acc_op)
        ACC_N_ADD:  norm_q[cmd_i.comp] <= n_sel + NormW'(prod_q);
        ACC_N_SUB:  norm_q[cmd_i.comp] <= n_sel - NormW'(prod_q);
        ACC_DOT_LO: dot_q <= dot_q + DotW'(prod_q);
        ACC_DOT_HI: dot_q <= dot_q + (DotW'(prod_q) <<< SplitW);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      tag_q <= face_id_q;
      for (int i = 0; i < 3; i++) nout_q[i] <= flip ? -norm_q[i] : norm_q[i];
      flip_q    <= flip;
      ovf_out_q <= ovf_q;
    end
  end

  assign done_o           = done_q;
  assign face_tag_o       = tag_q;
  assign normal_x_o       = nout_q[0];
  assign normal_y_o       = nout_q[1];
  assign normal_z_o       = nout_q[2];
  assign was_flipped_o    = flip_q;
  assign count_overflow_o = ovf_out_q;

endmodule

FILE: src/polygon_face_normal_oriented.sv
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------------
// input    | start_i, busy_o    | face_id_i, vertex_kind_i, coord_x/y/z_i, last_item_i
// result   | done_o (strobe)    | face_tag_o, normal_x/y/z_o, was_flipped_o,
//          |                    | count_overflow_o
//
// an item is taken at an edge with start_i high and busy_o low
// cell vertex, first or second face vertex, or a dropped vertex: busy for the update step only
// face vertex from the third on: also busy through the cross steps, as the six
//   products of the cross product go one by one through the single 30x30 multiplier
// last item: then the dot product for orientation, per component, and the emit step;
//   done_o pulses the cycle after emit, while the next item may already be taken
// reset clears the sums and counters and idles the block; results cannot be held off
module polygon_face_normal_oriented
  import pfno_pkg::*;
#(
  parameter int unsigned MAX_FACE_VERTS = DefMaxFaceVerts,
  parameter int unsigned MAX_CELL_VERTS = DefMaxCellVerts
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // item side
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [TagW-1:0]          face_id_i,
  input  logic                     vertex_kind_i,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic signed [CoordW-1:0] coord_z_i,
  input  logic                     last_item_i,
  // result side
  output logic                     done_o,
  output logic [TagW-1:0]          face_tag_o,
  output logic signed [NormW-1:0]  normal_x_o,
  output logic signed [NormW-1:0]  normal_y_o,
  output logic signed [NormW-1:0]  normal_z_o,
  output logic                     was_flipped_o,
  output logic                     count_overflow_o
);

  pfno_cmd_t  cmd;
  pfno_stat_t stat;

  // sequencer: decides per item which accumulations run and in what order
  pfno_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // datapath: fan origin, running normal, cell sum, shared multiplier, dot product
  pfno_datapath #(
    .MAX_FACE_VERTS(MAX_FACE_VERTS),
    .MAX_CELL_VERTS(MAX_CELL_VERTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .face_id_i       (face_id_i),
    .vertex_kind_i   (vertex_kind_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .last_item_i     (last_item_i),
    .done_o          (done_o),
    .face_tag_o      (face_tag_o),
    .normal_x_o      (normal_x_o),
    .normal_y_o      (normal_y_o),
    .normal_z_o      (normal_z_o),
    .was_flipped_o   (was_flipped_o),
    .count_overflow_o(count_overflow_o)
  );

  // a taken item always keeps the block busy for at least the update cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("item taken but block not busy");

  // a result needs the finishing sequence, so strobes never come back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // a result only follows a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without preceding work");

endmodule
